### rtl/core/terminal_net_label_table_defines.svh
// Assertion macros used by the terminal net label table top level
`ifndef TERMINAL_NET_LABEL_TABLE_DEFINES_SVH
`define TERMINAL_NET_LABEL_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TNLT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TNLT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TNLT_ASSERT(name, prop, msg)
`define TNLT_NEVER(name, cond, msg)
`endif
`endif

### rtl/core/tnlt_pkg.sv
// Constants, codes and types of the terminal net label table
package tnlt_pkg;
	localparam int MAX_COMPONENTS = 64;
	localparam int MAX_TERMINALS  = 4;
	localparam int MAX_LABEL      = 1023;
	localparam int NSLOTS   = MAX_COMPONENTS * MAX_TERMINALS;
	localparam int SLOT_W   = $clog2(MAX_COMPONENTS);
	localparam int TERM_W   = $clog2(MAX_TERMINALS);
	localparam int TIDX_W   = SLOT_W + TERM_W;
	localparam int TCNT_W   = 3;
	localparam int NLABELS  = MAX_LABEL + 1;
	localparam int LADDR_W  = $clog2(NLABELS);
	localparam int LABEL_W  = 11;
	localparam int NXT_W    = LADDR_W + 1;
	localparam int GCNT_W   = $clog2(MAX_COMPONENTS + 1);
	localparam int UCNT_W   = 2;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;

	localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CONN = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FREE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REM  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJ  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	localparam logic signed [LABEL_W-1:0] LABEL_FREE = -11'sd1;
	localparam logic signed [LABEL_W-1:0] LABEL_GND  = 11'sd0;

	typedef enum logic [1:0] {UC_NONE, UC_READ, UC_WRITE} uc_op_t;

	typedef struct packed {
		uc_op_t               op;
		logic [LADDR_W-1:0]   addr;
		logic [UCNT_W-1:0]    wdata;
	} uc_req_t;
endpackage

### rtl/core/tnlt_req_if.sv
// Request and response channel interfaces of the terminal net label table
interface tnlt_req_if;
	logic                           valid;
	logic                           ready;
	logic [tnlt_pkg::REQ_W-1:0]     req_type;
	logic [tnlt_pkg::SLOT_W-1:0]    comp_slot;
	logic [tnlt_pkg::TERM_W-1:0]    term_index;
	logic [tnlt_pkg::SLOT_W-1:0]    other_slot;
	logic [tnlt_pkg::TERM_W-1:0]    other_term;
	logic [tnlt_pkg::TCNT_W-1:0]    term_count;
	logic                           is_ground;
	modport source(output valid, req_type, comp_slot, term_index, other_slot, other_term,
		term_count, is_ground, input ready);
	modport sink(input valid, req_type, comp_slot, term_index, other_slot, other_term,
		term_count, is_ground, output ready);
endinterface

interface tnlt_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [tnlt_pkg::STAT_W-1:0]           status;
	logic signed [tnlt_pkg::LABEL_W-1:0]   label;
	logic                                  floating;
	modport source(output valid, status, label, floating, input ready);
	modport sink(input valid, status, label, floating, output ready);
endinterface

### rtl/core/terminal_net_label_table.sv
// Top level of the terminal net label table: sequencer, label and component stores
//
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | req_type, comp_slot, term_index, other_slot, other_term,
//          |     |               | term_count, is_ground
//  rsp     | out | valid / ready | status, label, floating
//
// One request at a time. After lookup and the writes, each pass walks all 256 terminal
// slots through one shared read port: relabel (connect that merges nets only), use count,
// floating check and count clearing. After reset the use count memory is swept to zero,
// during which no request is taken. A result waits in the output register while the next
// request is taken; a new result waits for it to leave.
`include "terminal_net_label_table_defines.svh"
module terminal_net_label_table (
	input logic          clk,
	input logic          arst_n,
	tnlt_req_if.sink     req,
	tnlt_rsp_if.source   rsp
);
	typedef enum logic [4:0] {
		S_IDLE, S_LK1, S_LK2, S_LK3, S_LK4, S_LK5, S_EXEC, S_INIT, S_WA, S_WB,
		S_RL1, S_RL2, S_CN1, S_CN2, S_CN3, S_CK1, S_CK2, S_CK3, S_CL1, S_CL2,
		S_FN1, S_FN2, S_DONE
	} state_t;

	localparam logic [tnlt_pkg::TIDX_W-1:0] SCAN_LAST = tnlt_pkg::TIDX_W'(tnlt_pkg::NSLOTS - 1);

	state_t state_q;

	// stores
	logic signed [tnlt_pkg::LABEL_W-1:0] term_mem [tnlt_pkg::NSLOTS];
	logic [tnlt_pkg::TCNT_W:0]           comp_mem [tnlt_pkg::MAX_COMPONENTS];
	logic [tnlt_pkg::MAX_COMPONENTS-1:0] present_q;

	// request fields
	logic [tnlt_pkg::REQ_W-1:0]  type_q;
	logic [tnlt_pkg::SLOT_W-1:0] slot_q, oslot_q;
	logic [tnlt_pkg::TERM_W-1:0] term_q, oterm_q;
	logic [tnlt_pkg::TCNT_W-1:0] tcnt_q;
	logic                        gnd_q;

	logic ex1_q, ex2_q, gnd1_q, rel_q, wr2_q, remove_q, float_q;
	logic signed [tnlt_pkg::LABEL_W-1:0] lab1_q, lab2_q, va_q, vb_q, from_q, to_q;
	logic [tnlt_pkg::STAT_W-1:0]         status_q;
	logic [tnlt_pkg::TIDX_W-1:0]         scan_q;
	logic [tnlt_pkg::LADDR_W-1:0]        hold_q;
	logic [tnlt_pkg::NXT_W-1:0]          next_label_q;
	logic [tnlt_pkg::GCNT_W-1:0]         gcnt_q;

	logic signed [tnlt_pkg::LABEL_W-1:0] trd_q;
	logic [tnlt_pkg::TCNT_W:0]           crd_q;

	// output register
	logic                                rsp_valid_q, rsp_float_q;
	logic [tnlt_pkg::STAT_W-1:0]         rsp_status_q;
	logic signed [tnlt_pkg::LABEL_W-1:0] rsp_label_q, lab_out_q;

	// memory port controls
	logic [tnlt_pkg::TIDX_W-1:0]         tr_addr, tw_addr;
	logic                                tw_en;
	logic signed [tnlt_pkg::LABEL_W-1:0] tw_data;
	logic [tnlt_pkg::SLOT_W-1:0]         cr_addr;
	logic                                cw_en;

	tnlt_pkg::uc_req_t           uc_req;
	logic [tnlt_pkg::UCNT_W-1:0] uc_rdata;
	logic                        uc_ready;

	logic scan_act, add_ok, free_it, scan_end, out_load;
	logic signed [tnlt_pkg::LABEL_W-1:0] fresh;

	tnlt_use_count u_use_count (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (uc_req),
		.rdata (uc_rdata),
		.ready (uc_ready)
	);

	// scan slot holds a live terminal
	assign scan_act = present_q[scan_q[tnlt_pkg::TIDX_W-1:tnlt_pkg::TERM_W]] &&
		({1'b0, scan_q[tnlt_pkg::TERM_W-1:0]} < crd_q[tnlt_pkg::TCNT_W-1:0]);
	assign scan_end = (scan_q == SCAN_LAST);
	assign add_ok   = !present_q[slot_q] && (tcnt_q != '0) &&
		(tcnt_q <= tnlt_pkg::TCNT_W'(tnlt_pkg::MAX_TERMINALS));
	assign free_it  = remove_q && ((hold_q != '0 && uc_rdata == 2'd1) ||
		(hold_q == '0 && gcnt_q == '0));
	assign fresh    = {1'b0, next_label_q[tnlt_pkg::LADDR_W-1:0]};
	assign out_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// select memory addresses and writes per state
	always_comb begin
		tr_addr = scan_q;
		cr_addr = scan_q[tnlt_pkg::TIDX_W-1:tnlt_pkg::TERM_W];
		tw_en   = 1'b0;
		tw_addr = scan_q;
		tw_data = tnlt_pkg::LABEL_FREE;
		cw_en   = 1'b0;
		uc_req  = '{op: tnlt_pkg::UC_NONE, addr: trd_q[tnlt_pkg::LADDR_W-1:0], wdata: '0};
		case (state_q)
			S_LK1, S_FN1: begin
				cr_addr = slot_q;
				tr_addr = {slot_q, term_q};
			end
			S_LK2: cr_addr = oslot_q;
			S_LK3: tr_addr = {slot_q, term_q};
			S_LK4: tr_addr = {oslot_q, oterm_q};
			S_EXEC: cw_en = (type_q == tnlt_pkg::REQ_ADD) && add_ok;
			S_INIT: begin
				tw_en   = 1'b1;
				tw_data = (({1'b0, scan_q[tnlt_pkg::TERM_W-1:0]} < tcnt_q) && gnd_q) ?
					tnlt_pkg::LABEL_GND : tnlt_pkg::LABEL_FREE;
			end
			S_WA: begin
				tw_en   = 1'b1;
				tw_addr = {slot_q, term_q};
				tw_data = va_q;
			end
			S_WB: begin
				tw_en   = 1'b1;
				tw_addr = {oslot_q, oterm_q};
				tw_data = vb_q;
			end
			S_RL2: begin
				tw_en   = (trd_q == from_q);
				tw_data = to_q;
			end
			S_CN2, S_CK2: begin
				if (scan_act && !trd_q[tnlt_pkg::LABEL_W-1]) uc_req.op = tnlt_pkg::UC_READ;
			end
			S_CN3: begin
				uc_req.op    = tnlt_pkg::UC_WRITE;
				uc_req.addr  = hold_q;
				uc_req.wdata = (uc_rdata == 2'd2) ? 2'd2 : uc_rdata + 2'd1;
			end
			S_CK3: begin
				uc_req.addr = hold_q;
				if (free_it) begin
					uc_req.op = tnlt_pkg::UC_WRITE;
					tw_en     = 1'b1;
				end
			end
			S_CL2: begin
				if (scan_act && !trd_q[tnlt_pkg::LABEL_W-1]) uc_req.op = tnlt_pkg::UC_WRITE;
			end
			default: ;
		endcase
	end

	// label and component stores
	always_ff @(posedge clk) begin
		if (tw_en) term_mem[tw_addr] <= tw_data;
		trd_q <= term_mem[tr_addr];
		if (cw_en) comp_mem[slot_q] <= {gnd_q, tcnt_q};
		crd_q <= comp_mem[cr_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			present_q    <= '0;
			next_label_q <= tnlt_pkg::NXT_W'(1);
			gcnt_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						type_q   <= req.req_type;
						slot_q   <= req.comp_slot;
						term_q   <= req.term_index;
						oslot_q  <= req.other_slot;
						oterm_q  <= req.other_term;
						tcnt_q   <= req.term_count;
						gnd_q    <= req.is_ground;
						float_q  <= 1'b0;
						remove_q <= 1'b0;
						rel_q    <= 1'b0;
						wr2_q    <= 1'b0;
						status_q <= tnlt_pkg::ST_REJ;
						state_q  <= S_LK1;
					end
				end
				S_LK1: state_q <= S_LK2;
				S_LK2: begin
					ex1_q   <= present_q[slot_q] &&
						({1'b0, term_q} < crd_q[tnlt_pkg::TCNT_W-1:0]);
					gnd1_q  <= crd_q[tnlt_pkg::TCNT_W];
					state_q <= S_LK3;
				end
				S_LK3: begin
					ex2_q   <= present_q[oslot_q] &&
						({1'b0, oterm_q} < crd_q[tnlt_pkg::TCNT_W-1:0]);
					state_q <= S_LK4;
				end
				S_LK4: begin
					lab1_q  <= trd_q;
					state_q <= S_LK5;
				end
				S_LK5: begin
					lab2_q  <= trd_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					// an accepted add initializes its own slots, all else walks from zero
					scan_q <= (type_q == tnlt_pkg::REQ_ADD && add_ok) ?
						{slot_q, {tnlt_pkg::TERM_W{1'b0}}} : '0;
					unique case (type_q)
						tnlt_pkg::REQ_ADD: begin
							if (add_ok) begin
								present_q[slot_q] <= 1'b1;
								gcnt_q   <= gcnt_q + tnlt_pkg::GCNT_W'(gnd_q);
								status_q <= tnlt_pkg::ST_DONE;
								state_q  <= S_INIT;
							end else begin
								state_q  <= S_CN1;
							end
						end
						tnlt_pkg::REQ_CONN: begin
							if (slot_q != oslot_q && ex1_q && ex2_q) begin
								if (lab1_q[tnlt_pkg::LABEL_W-1] && lab2_q[tnlt_pkg::LABEL_W-1]) begin
									if (next_label_q > tnlt_pkg::NXT_W'(tnlt_pkg::MAX_LABEL)) begin
										status_q <= tnlt_pkg::ST_FULL;
										state_q  <= S_CN1;
									end else begin
										va_q         <= fresh;
										vb_q         <= fresh;
										next_label_q <= next_label_q + 1'b1;
										wr2_q        <= 1'b1;
										status_q     <= tnlt_pkg::ST_DONE;
										state_q      <= S_WA;
									end
								end else if (lab1_q == '0 || lab2_q == '0) begin
									// ground absorbs the other net
									va_q     <= tnlt_pkg::LABEL_GND;
									vb_q     <= tnlt_pkg::LABEL_GND;
									wr2_q    <= 1'b1;
									to_q     <= tnlt_pkg::LABEL_GND;
									status_q <= tnlt_pkg::ST_DONE;
									state_q  <= S_WA;
									if (lab2_q != '0) begin
										from_q <= lab2_q;
										rel_q  <= !lab2_q[tnlt_pkg::LABEL_W-1];
									end else begin
										from_q <= lab1_q;
										rel_q  <= !lab1_q[tnlt_pkg::LABEL_W-1];
									end
								end else if (!lab1_q[tnlt_pkg::LABEL_W-1]) begin
									va_q     <= lab1_q;
									vb_q     <= lab1_q;
									wr2_q    <= 1'b1;
									from_q   <= lab2_q;
									to_q     <= lab1_q;
									rel_q    <= !lab2_q[tnlt_pkg::LABEL_W-1];
									status_q <= tnlt_pkg::ST_DONE;
									state_q  <= S_WA;
								end else begin
									va_q     <= lab2_q;
									status_q <= tnlt_pkg::ST_DONE;
									state_q  <= S_WA;
								end
							end else begin
								state_q <= S_CN1;
							end
						end
						tnlt_pkg::REQ_FREE: begin
							if (ex1_q) begin
								va_q     <= tnlt_pkg::LABEL_FREE;
								status_q <= tnlt_pkg::ST_DONE;
								state_q  <= S_WA;
							end else begin
								state_q  <= S_CN1;
							end
						end
						tnlt_pkg::REQ_REM: begin
							if (present_q[slot_q]) begin
								present_q[slot_q] <= 1'b0;
								gcnt_q   <= gcnt_q - tnlt_pkg::GCNT_W'(gnd1_q);
								remove_q <= 1'b1;
								status_q <= tnlt_pkg::ST_DONE;
							end
							state_q <= S_CN1;
						end
						tnlt_pkg::REQ_READ: begin
							if (ex1_q) status_q <= tnlt_pkg::ST_DONE;
							state_q <= S_CN1;
						end
						default: state_q <= S_CN1;
					endcase
				end
				S_INIT: begin
					if (scan_q[tnlt_pkg::TERM_W-1:0] == '1) begin
						scan_q  <= '0;
						state_q <= S_CN1;
					end else begin
						scan_q  <= scan_q + 1'b1;
					end
				end
				S_WA: begin
					if (wr2_q) state_q <= S_WB;
					else       state_q <= S_CN1;
				end
				S_WB: state_q <= rel_q ? S_RL1 : S_CN1;
				// relabel walk
				S_RL1: state_q <= S_RL2;
				S_RL2: begin
					scan_q  <= scan_q + 1'b1;
					state_q <= scan_end ? S_CN1 : S_RL1;
				end
				// use count walk
				S_CN1: state_q <= S_CN2;
				S_CN2: begin
					hold_q <= trd_q[tnlt_pkg::LADDR_W-1:0];
					if (scan_act && !trd_q[tnlt_pkg::LABEL_W-1]) begin
						state_q <= S_CN3;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= scan_end ? S_CK1 : S_CN1;
					end
				end
				S_CN3: begin
					scan_q  <= scan_q + 1'b1;
					state_q <= scan_end ? S_CK1 : S_CN1;
				end
				// floating check walk, dropping lone terminals after a removal
				S_CK1: state_q <= S_CK2;
				S_CK2: begin
					hold_q <= trd_q[tnlt_pkg::LADDR_W-1:0];
					if (scan_act && !trd_q[tnlt_pkg::LABEL_W-1]) begin
						state_q <= S_CK3;
					end else begin
						if (scan_act) float_q <= 1'b1;
						scan_q  <= scan_q + 1'b1;
						state_q <= scan_end ? S_CL1 : S_CK1;
					end
				end
				S_CK3: begin
					if (free_it || uc_rdata < 2'd2) float_q <= 1'b1;
					scan_q  <= scan_q + 1'b1;
					state_q <= scan_end ? S_CL1 : S_CK1;
				end
				// count clearing walk
				S_CL1: state_q <= S_CL2;
				S_CL2: begin
					scan_q  <= scan_q + 1'b1;
					state_q <= scan_end ? S_FN1 : S_CL1;
				end
				S_FN1: state_q <= S_FN2;
				S_FN2: begin
					lab_out_q <= (present_q[slot_q] &&
						({1'b0, term_q} < crd_q[tnlt_pkg::TCNT_W-1:0])) ?
						trd_q : tnlt_pkg::LABEL_FREE;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_label_q  <= lab_out_q;
						rsp_float_q  <= float_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready    = (state_q == S_IDLE) && uc_ready;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.label    = rsp_label_q;
	assign rsp.floating = rsp_float_q;

	`TNLT_NEVER(a_rdy_clr, req.ready && !uc_ready, "request taken during count sweep")
	`TNLT_ASSERT(a_lab_mono, 1'b1 |=> next_label_q >= $past(next_label_q), "label counter fell")
	`TNLT_ASSERT(a_full, rsp.valid && rsp.status == tnlt_pkg::ST_FULL |-> next_label_q > tnlt_pkg::NXT_W'(tnlt_pkg::MAX_LABEL), "full without exhaustion")
	`TNLT_NEVER(a_gcnt, gcnt_q > tnlt_pkg::GCNT_W'(tnlt_pkg::MAX_COMPONENTS), "ground count overflow")
endmodule

### rtl/core/tnlt_use_count.sv
// Per-label use counter memory with a clearing sweep after reset
module tnlt_use_count (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnlt_pkg::uc_req_t             req,
	output logic [tnlt_pkg::UCNT_W-1:0]   rdata,
	output logic                          ready
);
	logic [tnlt_pkg::UCNT_W-1:0]  mem [tnlt_pkg::NLABELS];
	logic                         clr_q;
	logic [tnlt_pkg::LADDR_W-1:0] clr_addr_q;

	// sweep all counters to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) clr_q <= 1'b0;
		end
	end

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.op == tnlt_pkg::UC_WRITE) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

	assign ready = !clr_q;
endmodule

### dv/tb_terminal_net_label_table.sv
// Testbench for the terminal net label table: directed and random requests checked against a predictor
`timescale 1ns / 100ps
module tb_terminal_net_label_table;
	logic clk;
	logic arst_n;
	tnlt_req_if req ();
	tnlt_rsp_if rsp ();

	terminal_net_label_table dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	typedef struct packed {
		logic [tnlt_pkg::STAT_W-1:0]         status;
		logic signed [tnlt_pkg::LABEL_W-1:0] label;
		logic                                floating;
	} result_t;

	// predictor state
	int      net_of[tnlt_pkg::NSLOTS];
	bit      placed[tnlt_pkg::MAX_COMPONENTS];
	int      pins[tnlt_pkg::MAX_COMPONENTS];
	bit      grounded[tnlt_pkg::MAX_COMPONENTS];
	int      fresh_label;
	result_t pending[$];
	int      errors;
	bit      rx_hold;
	int      ns = 8;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit pin_ok(int s, int t);
		return placed[s] && t < pins[s];
	endfunction

	function automatic void retag(int from, int to);
		for (int i = 0; i < tnlt_pkg::NSLOTS; i++)
			if (net_of[i] == from) net_of[i] = to;
	endfunction

	function automatic void tally(ref int uses[tnlt_pkg::NLABELS]);
		int l;
		foreach (uses[i]) uses[i] = 0;
		for (int c = 0; c < tnlt_pkg::MAX_COMPONENTS; c++)
			if (placed[c])
				for (int t = 0; t < pins[c]; t++) begin
					l = net_of[c*tnlt_pkg::MAX_TERMINALS+t];
					if (l >= 0 && l <= tnlt_pkg::MAX_LABEL) uses[l]++;
				end
	endfunction

	function automatic bit any_floating();
		int uses[tnlt_pkg::NLABELS];
		int l;
		tally(uses);
		for (int c = 0; c < tnlt_pkg::MAX_COMPONENTS; c++)
			if (placed[c])
				for (int t = 0; t < pins[c]; t++) begin
					l = net_of[c*tnlt_pkg::MAX_TERMINALS+t];
					if (l < 0 || l > tnlt_pkg::MAX_LABEL || uses[l] < 2) return 1'b1;
				end
		return 1'b0;
	endfunction

	function automatic logic [tnlt_pkg::STAT_W-1:0] join_pins(int s1, int t1, int s2, int t2);
		int a, b, l1, l2, old;
		if (s1 == s2 || !pin_ok(s1, t1) || !pin_ok(s2, t2)) return tnlt_pkg::ST_REJ;
		a = s1*tnlt_pkg::MAX_TERMINALS + t1;
		b = s2*tnlt_pkg::MAX_TERMINALS + t2;
		l1 = net_of[a];
		l2 = net_of[b];
		if (l1 < 0 && l2 < 0) begin
			if (fresh_label > tnlt_pkg::MAX_LABEL) return tnlt_pkg::ST_FULL;
			net_of[a] = fresh_label;
			net_of[b] = fresh_label;
			fresh_label++;
			return tnlt_pkg::ST_DONE;
		end
		if (l1 == 0 || l2 == 0) begin
			old = -1;
			if (l1 != 0) old = l1;
			if (l2 != 0) old = l2;
			net_of[a] = 0;
			net_of[b] = 0;
			if (old > 0) retag(old, 0);
			return tnlt_pkg::ST_DONE;
		end
		if (l1 > 0) begin
			net_of[b] = l1;
			if (l2 > 0) retag(l2, l1);
		end else begin
			net_of[a] = l2;
		end
		return tnlt_pkg::ST_DONE;
	endfunction

	function automatic logic [tnlt_pkg::STAT_W-1:0] drop_part(int s);
		int uses[tnlt_pkg::NLABELS];
		bit gnd_left;
		int i, l;
		if (!placed[s]) return tnlt_pkg::ST_REJ;
		for (int t = 0; t < tnlt_pkg::MAX_TERMINALS; t++)
			net_of[s*tnlt_pkg::MAX_TERMINALS+t] = -1;
		placed[s] = 0;
		pins[s] = 0;
		grounded[s] = 0;
		tally(uses);
		gnd_left = 0;
		for (int c = 0; c < tnlt_pkg::MAX_COMPONENTS; c++)
			if (placed[c] && grounded[c]) gnd_left = 1;
		for (int c = 0; c < tnlt_pkg::MAX_COMPONENTS; c++)
			if (placed[c])
				for (int t = 0; t < pins[c]; t++) begin
					i = c*tnlt_pkg::MAX_TERMINALS + t;
					l = net_of[i];
					if ((l > 0 && l <= tnlt_pkg::MAX_LABEL && uses[l] == 1) ||
						(l == 0 && !gnd_left))
						net_of[i] = -1;
				end
		return tnlt_pkg::ST_DONE;
	endfunction

	function automatic result_t predict_label(logic [tnlt_pkg::REQ_W-1:0] op, int s, int t,
			int os, int ot, int cnt, bit g);
		result_t r;
		r.status = tnlt_pkg::ST_REJ;
		case (op)
			tnlt_pkg::REQ_ADD: if (!placed[s] && cnt >= 1 && cnt <= tnlt_pkg::MAX_TERMINALS) begin
				placed[s] = 1;
				pins[s] = cnt;
				grounded[s] = g;
				for (int k = 0; k < tnlt_pkg::MAX_TERMINALS; k++)
					net_of[s*tnlt_pkg::MAX_TERMINALS+k] = (k < cnt && g) ? 0 : -1;
				r.status = tnlt_pkg::ST_DONE;
			end
			tnlt_pkg::REQ_CONN: r.status = join_pins(s, t, os, ot);
			tnlt_pkg::REQ_FREE: if (pin_ok(s, t)) begin
				net_of[s*tnlt_pkg::MAX_TERMINALS+t] = -1;
				r.status = tnlt_pkg::ST_DONE;
			end
			tnlt_pkg::REQ_REM: r.status = drop_part(s);
			tnlt_pkg::REQ_READ: if (pin_ok(s, t)) r.status = tnlt_pkg::ST_DONE;
			default: ;
		endcase
		r.label = pin_ok(s, t) ?
			tnlt_pkg::LABEL_W'(net_of[s*tnlt_pkg::MAX_TERMINALS+t]) : tnlt_pkg::LABEL_FREE;
		r.floating = any_floating();
		return r;
	endfunction

	// send one word and queue its expected result
	task automatic send_word(logic [tnlt_pkg::REQ_W-1:0] op, int s, int t, int os, int ot,
			int cnt, bit g);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// valid always goes low between one word and the next
		repeat (gap + 1) @(posedge clk);
		req.valid      <= 1'b1;
		req.req_type   <= op;
		req.comp_slot  <= tnlt_pkg::SLOT_W'(s);
		req.term_index <= tnlt_pkg::TERM_W'(t);
		req.other_slot <= tnlt_pkg::SLOT_W'(os);
		req.other_term <= tnlt_pkg::TERM_W'(ot);
		req.term_count <= tnlt_pkg::TCNT_W'(cnt);
		req.is_ground  <= g;
		do @(posedge clk); while (!req.ready);
		pending.insert(pending.size(), predict_label(op, s, t, os, ot, cnt, g));
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() != 0) @(posedge clk);
	endtask

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending.size() == 0) begin
				$error("result with no expectation");
				errors++;
			end else begin
				e = pending.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); errors++;
				end
				if (rsp.label !== e.label) begin
					$error("label exp %0d got %0d", e.label, rsp.label); errors++;
				end
				if (rsp.floating !== e.floating) begin
					$error("floating exp %0d got %0d", e.floating, rsp.floating); errors++;
				end
			end
		end
	end

	// receiver stalls: short random gaps, with a long hold when asked
	always @(posedge clk) begin
		if (!arst_n) rsp.ready <= 1'b0;
		else if (rx_hold) rsp.ready <= 1'b0;
		else if ($urandom_range(0, 49) == 0) rsp.ready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) rsp.ready <= ~rsp.ready;
		else rsp.ready <= 1'b1;
	end

	task automatic test_directed();
		send_word(tnlt_pkg::REQ_READ, 0, 0, 0, 0, 1, 0);
		send_word(tnlt_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_ADD, 0, 0, 0, 0, 5, 0);
		send_word(tnlt_pkg::REQ_ADD, 0, 3, 0, 0, 4, 0);
		send_word(tnlt_pkg::REQ_ADD, 0, 0, 0, 0, 2, 1);
		send_word(tnlt_pkg::REQ_ADD, 63, 3, 0, 0, 4, 1);
		send_word(tnlt_pkg::REQ_ADD, 1, 0, 0, 0, 1, 0);
		send_word(tnlt_pkg::REQ_CONN, 0, 0, 0, 1, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 0, 3, 1, 0, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 0, 2, 1, 0, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 1, 0, 63, 3, 0, 0);
		send_word(tnlt_pkg::REQ_ADD, 2, 0, 0, 0, 2, 0);
		send_word(tnlt_pkg::REQ_ADD, 3, 0, 0, 0, 2, 0);
		send_word(tnlt_pkg::REQ_CONN, 2, 1, 3, 1, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 2, 0, 3, 0, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 3, 0, 2, 1, 0, 0);
		send_word(tnlt_pkg::REQ_CONN, 2, 0, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_FREE, 2, 0, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_FREE, 2, 3, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_REM, 0, 0, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_REM, 63, 0, 0, 0, 0, 0);
		send_word(tnlt_pkg::REQ_REM, 5, 0, 0, 0, 0, 0);
		send_word(3'd5, 2, 0, 0, 0, 0, 0);
		send_word(3'd7, 63, 3, 63, 3, 7, 1);
	endtask

	// random traffic on a small set of slots so that nets form and merge
	task automatic test_random(int n);
		int r, s, os;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, ns-1);
			os = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, ns-1);
			if (r < 20)
				send_word(tnlt_pkg::REQ_ADD, s, $urandom_range(0, 3), os, $urandom_range(0, 3),
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
					$urandom_range(0, 4) == 0);
			else if (r < 65)
				send_word(tnlt_pkg::REQ_CONN, s, $urandom_range(0, 3), os, $urandom_range(0, 3),
					0, 0);
			else if (r < 75)
				send_word(tnlt_pkg::REQ_FREE, s, $urandom_range(0, 3), 0, 0, 0, 0);
			else if (r < 85)
				send_word(tnlt_pkg::REQ_REM, s, 0, 0, 0, 0, 0);
			else if (r < 97)
				send_word(tnlt_pkg::REQ_READ, s, $urandom_range(0, 3), 0, 0, 0, 0);
			else
				send_word(tnlt_pkg::REQ_W'($urandom_range(5, 7)), s, $urandom_range(0, 3), os,
					$urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 1));
		end
	endtask

	// hold the receiver off while words keep coming
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1;
				repeat (12000) @(posedge clk);
				rx_hold = 0;
			end
			test_random(5);
		join
		drain();
	endtask

	initial begin
		errors = 0;
		rx_hold = 0;
		fresh_label = 1;
		foreach (net_of[i]) net_of[i] = -1;
		foreach (placed[i]) begin
			placed[i] = 0;
			pins[i] = 0;
			grounded[i] = 0;
		end
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = tnlt_pkg::REQ_READ;
		req.comp_slot = '0;
		req.term_index = '0;
		req.other_slot = '0;
		req.other_term = '0;
		req.term_count = '0;
		req.is_ground = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(200);
		test_backpressure();
		drain();
		ns = 20;
		test_random(250);
		drain();
		repeat (3000) @(posedge clk);
		if (errors == 0 && pending.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin
		#60ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
